@@ rtl/abbc_pkg.sv @@
package abbc_pkg;

    localparam int MAX_DIM = 4096;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_ALPHA_TOLERANCE = 3'd2,
        CFG_X_OFFSET        = 3'd3,
        CFG_Y_OFFSET        = 3'd4,
        CFG_PREV_CROP_LEFT  = 3'd5,
        CFG_PREV_CROP_TOP   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] width;
        logic [12:0] height;
    } t_rect;

endpackage

@@ rtl/abbc_out.sv @@
module abbc_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rect_valid,
    input  abbc_pkg::t_rect       i_rect,
    output logic                  o_take,
    input  logic [15:0]           i_x_offset,
    input  logic [15:0]           i_y_offset,
    input  logic [11:0]           i_prev_left,
    input  logic [11:0]           i_prev_top,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [11:0]           o_crop_left,
    output logic [11:0]           o_crop_top,
    output logic [12:0]           o_crop_width,
    output logic [12:0]           o_crop_height,
    output logic signed [15:0]    o_new_x_offset,
    output logic signed [15:0]    o_new_y_offset
);
    import abbc_pkg::*;

    logic                r_vld;
    t_rect               r_rect;
    logic signed [15:0]  r_new_x;
    logic signed [15:0]  r_new_y;
    logic signed [15:0]  n_new_x;
    logic signed [15:0]  n_new_y;

    function automatic logic signed [15:0] adjust(input logic [15:0] off,
                                                 input logic [11:0] edge_pos,
                                                 input logic [11:0] prev);
        logic signed [17:0] off_ext;
        logic signed [17:0] shift;
        logic signed [17:0] sum;
        off_ext = {{2{off[15]}}, off};
        shift   = $signed({6'd0, edge_pos}) - $signed({6'd0, prev});
        sum     = off_ext - shift;
        if (sum > 18'sd32767) begin
            adjust = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            adjust = 16'sh8000;
        end else begin
            adjust = sum[15:0];
        end
    endfunction

    assign n_new_x = adjust(i_x_offset, i_rect.left, i_prev_left);
    assign n_new_y = adjust(i_y_offset, i_rect.top, i_prev_top);
    assign o_take  = !r_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_rect_valid;
        end
        if (o_take && i_rect_valid) begin
            r_rect  <= i_rect;
            r_new_x <= n_new_x;
            r_new_y <= n_new_y;
        end
    end

    assign o_out_valid    = r_vld;
    assign o_crop_left    = r_rect.left;
    assign o_crop_top     = r_rect.top;
    assign o_crop_width   = r_rect.width;
    assign o_crop_height  = r_rect.height;
    assign o_new_x_offset = r_new_x;
    assign o_new_y_offset = r_new_y;

endmodule

@@ rtl/alpha_bounding_box_crop_top.sv @@
// Alpha bounding box of a raster frame, one pixel accepted per clock.
// Tracking registers update on each accepted pixel; the last pixel of a frame
// loads a bounds register at its accepting edge, and the crop moves on to the
// result register once the output stage can take it.
// Throughput: one pixel per cycle; input stalls only when both the bounds and
// the result registers hold undelivered frames.
// Synchronous active-low reset clears tracking, valids and configuration registers to defaults.
module alpha_bounding_box_crop_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_alpha,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [11:0]        o_crop_left,
    output logic [11:0]        o_crop_top,
    output logic [12:0]        o_crop_width,
    output logic [12:0]        o_crop_height,
    output logic signed [15:0] o_new_x_offset,
    output logic signed [15:0] o_new_y_offset
);
    import abbc_pkg::*;

    localparam int CNT_W_RAW = $clog2(MAX_DIM);
    localparam int CNT_W     = (CNT_W_RAW > 13) ? 13 : CNT_W_RAW;
    localparam int DIM_CAP   = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
    localparam logic [CNT_W-1:0] MIN_RST = (CNT_W >= 12) ? CNT_W'(12'hFFF) : '1;

    logic [12:0]       r_image_width;
    logic [12:0]       r_image_height;
    logic [7:0]        r_tol;
    logic [15:0]       r_x_offset;
    logic [15:0]       r_y_offset;
    logic [11:0]       r_prev_left;
    logic [11:0]       r_prev_top;

    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_min_col;
    logic [CNT_W-1:0]  r_max_col;
    logic [CNT_W-1:0]  r_min_row;
    logic [CNT_W-1:0]  r_max_row;
    logic              r_any;

    logic              r_snap_vld;
    logic [CNT_W-1:0]  r_s_min_col;
    logic [CNT_W-1:0]  r_s_max_col;
    logic [CNT_W-1:0]  r_s_min_row;
    logic [CNT_W-1:0]  r_s_max_row;
    logic              r_s_any;

    logic [CNT_W-1:0]  n_min_col;
    logic [CNT_W-1:0]  n_max_col;
    logic [CNT_W-1:0]  n_min_row;
    logic [CNT_W-1:0]  n_max_row;
    logic              n_any;

    logic [13:0]       w_eff;
    logic [13:0]       h_eff;
    logic [13:0]       col_inc;
    logic [13:0]       row_inc;
    logic              vis;
    logic              line_end;
    logic              frame_end;
    logic              in_acc;
    logic              out_take;
    t_rect             rect;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 13'd1;
            r_image_height <= 13'd1;
            r_tol          <= '0;
            r_x_offset     <= '0;
            r_y_offset     <= '0;
            r_prev_left    <= '0;
            r_prev_top     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:     r_image_width  <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT:    r_image_height <= i_cfg_data[12:0];
                CFG_ALPHA_TOLERANCE: r_tol          <= i_cfg_data[7:0];
                CFG_X_OFFSET:        r_x_offset     <= i_cfg_data;
                CFG_Y_OFFSET:        r_y_offset     <= i_cfg_data;
                CFG_PREV_CROP_LEFT:  r_prev_left    <= i_cfg_data[11:0];
                CFG_PREV_CROP_TOP:   r_prev_top     <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_image_width == 13'd0) begin
            w_eff = 14'd1;
        end else if (32'(r_image_width) > 32'(MAX_DIM)) begin
            w_eff = 14'(DIM_CAP);
        end else begin
            w_eff = {1'b0, r_image_width};
        end
        if (r_image_height == 13'd0) begin
            h_eff = 14'd1;
        end else if (32'(r_image_height) > 32'(MAX_DIM)) begin
            h_eff = 14'(DIM_CAP);
        end else begin
            h_eff = {1'b0, r_image_height};
        end
    end

    assign vis       = i_alpha > r_tol;
    assign col_inc   = 14'(r_col) + 14'd1;
    assign row_inc   = 14'(r_row) + 14'd1;
    assign line_end  = !(col_inc < w_eff);
    assign frame_end = line_end && !(row_inc < h_eff);

    assign n_min_col = (vis && r_col < r_min_col) ? r_col : r_min_col;
    assign n_max_col = (vis && r_col > r_max_col) ? r_col : r_max_col;
    assign n_min_row = (vis && r_row < r_min_row) ? r_row : r_min_row;
    assign n_max_row = (vis && r_row > r_max_row) ? r_row : r_max_row;
    assign n_any     = r_any | vis;

    assign o_in_ready = !r_snap_vld || out_take;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= MIN_RST;
            r_max_col <= '0;
            r_min_row <= MIN_RST;
            r_max_row <= '0;
            r_any     <= 1'b0;
        end else if (in_acc) begin
            if (frame_end) begin
                r_col     <= '0;
                r_row     <= '0;
                r_min_col <= MIN_RST;
                r_max_col <= '0;
                r_min_row <= MIN_RST;
                r_max_row <= '0;
                r_any     <= 1'b0;
            end else begin
                r_col     <= line_end ? '0 : CNT_W'(col_inc);
                r_row     <= line_end ? CNT_W'(row_inc) : r_row;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_any     <= n_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (in_acc && frame_end) begin
            r_snap_vld <= 1'b1;
        end else if (out_take) begin
            r_snap_vld <= 1'b0;
        end
        if (in_acc && frame_end) begin
            r_s_min_col <= n_min_col;
            r_s_max_col <= n_max_col;
            r_s_min_row <= n_min_row;
            r_s_max_row <= n_max_row;
            r_s_any     <= n_any;
        end
    end

    always_comb begin
        if (r_s_any) begin
            rect.left   = 12'(r_s_min_col);
            rect.top    = 12'(r_s_min_row);
            rect.width  = 13'(14'(r_s_max_col) - 14'(r_s_min_col) + 14'd1);
            rect.height = 13'(14'(r_s_max_row) - 14'(r_s_min_row) + 14'd1);
        end else begin
            rect.left   = '0;
            rect.top    = '0;
            rect.width  = 13'd1;
            rect.height = 13'd1;
        end
    end

    abbc_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rect_valid   (r_snap_vld),
        .i_rect         (rect),
        .o_take         (out_take),
        .i_x_offset     (r_x_offset),
        .i_y_offset     (r_y_offset),
        .i_prev_left    (r_prev_left),
        .i_prev_top     (r_prev_top),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_crop_left    (o_crop_left),
        .o_crop_top     (o_crop_top),
        .o_crop_width   (o_crop_width),
        .o_crop_height  (o_crop_height),
        .o_new_x_offset (o_new_x_offset),
        .o_new_y_offset (o_new_y_offset)
    );

endmodule

@@ rtl/abbc_check.sv @@
module abbc_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_crop_left,
    input logic [12:0] o_crop_width,
    input logic [12:0] o_crop_height
);

    // result request holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_crop_left) && $stable(o_crop_width))
        else $error("stalled result changed");

    a_rect_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_crop_width != 13'd0) && (o_crop_height != 13'd0))
        else $error("empty crop rectangle");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind alpha_bounding_box_crop_top abbc_check u_abbc_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_crop_left   (o_crop_left),
    .o_crop_width  (o_crop_width),
    .o_crop_height (o_crop_height)
);

@@ verif/alpha_bounding_box_crop_top_tb.sv @@
`timescale 1ns / 100ps

module alpha_bounding_box_crop_top_tb;
    import abbc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PIXELS  = 520;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        t_rect              rect;
        logic signed [15:0] x_off;
        logic signed [15:0] y_off;
    } t_crop_res;

    class crop_box_ledger;
        logic [12:0] img_w, img_h;
        logic [7:0]  tol;
        logic [15:0] x_off, y_off;
        logic [11:0] prev_left, prev_top;
        logic [11:0] col, row, min_col, max_col, min_row, max_row;
        bit          any_vis;
        t_crop_res   crops_due[$];
        int unsigned frames_seen;
        int unsigned crop_errs;

        function new();
            img_w = 13'd1;
            img_h = 13'd1;
            tol = 8'd0;
            x_off = 16'd0;
            y_off = 16'd0;
            prev_left = 12'd0;
            prev_top = 12'd0;
            frames_seen = 0;
            crop_errs = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            col = 12'd0;
            row = 12'd0;
            min_col = 12'hFFF;
            max_col = 12'd0;
            min_row = 12'hFFF;
            max_row = 12'd0;
            any_vis = 1'b0;
        endfunction

        function logic [12:0] clamp_dim(logic [12:0] v);
            if (v == 13'd0) return 13'd1;
            if (v > 13'd4096) return 13'd4096;
            return v;
        endfunction

        function logic signed [15:0] shift_offset(logic [15:0] off, logic [11:0] edge_pos,
                                                  logic [11:0] prev);
            int r;
            r = int'($signed(off)) - int'(edge_pos) + int'(prev);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] d);
            case (idx)
                CFG_IMAGE_WIDTH:     img_w = d[12:0];
                CFG_IMAGE_HEIGHT:    img_h = d[12:0];
                CFG_ALPHA_TOLERANCE: tol = d[7:0];
                CFG_X_OFFSET:        x_off = d;
                CFG_Y_OFFSET:        y_off = d;
                CFG_PREV_CROP_LEFT:  prev_left = d[11:0];
                CFG_PREV_CROP_TOP:   prev_top = d[11:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [7:0] a);
            logic [12:0] w, h;
            t_crop_res   res;
            w = clamp_dim(img_w);
            h = clamp_dim(img_h);
            if (a > tol) begin
                if (col < min_col) min_col = col;
                if (col > max_col) max_col = col;
                if (row < min_row) min_row = row;
                if (row > max_row) max_row = row;
                any_vis = 1'b1;
            end
            if ({1'b0, col} + 13'd1 < w) begin
                col = col + 12'd1;
                return;
            end
            col = 12'd0;
            if ({1'b0, row} + 13'd1 < h) begin
                row = row + 12'd1;
                return;
            end
            if (any_vis) begin
                res.rect.left   = min_col;
                res.rect.top    = min_row;
                res.rect.width  = {1'b0, max_col} - {1'b0, min_col} + 13'd1;
                res.rect.height = {1'b0, max_row} - {1'b0, min_row} + 13'd1;
            end else begin
                res.rect.left   = 12'd0;
                res.rect.top    = 12'd0;
                res.rect.width  = 13'd1;
                res.rect.height = 13'd1;
            end
            res.x_off = shift_offset(x_off, res.rect.left, prev_left);
            res.y_off = shift_offset(y_off, res.rect.top, prev_top);
            crops_due.push_back(res);
            frames_seen++;
            clear_frame();
        endfunction

        function void check_crop(t_crop_res got);
            t_crop_res exp_res;
            if (crops_due.size() == 0) begin
                if (crop_errs < 10)
                    $display("unexpected crop: left %0d top %0d w %0d h %0d x %0d y %0d",
                             got.rect.left, got.rect.top, got.rect.width, got.rect.height,
                             got.x_off, got.y_off);
                crop_errs++;
                return;
            end
            exp_res = crops_due.pop_front();
            if (got.rect.left !== exp_res.rect.left || got.rect.top !== exp_res.rect.top ||
                got.rect.width !== exp_res.rect.width ||
                got.rect.height !== exp_res.rect.height ||
                got.x_off !== exp_res.x_off || got.y_off !== exp_res.y_off) begin
                if (crop_errs < 10) begin
                    $display("crop mismatch, expected: left %0d top %0d w %0d h %0d x %0d y %0d",
                             exp_res.rect.left, exp_res.rect.top, exp_res.rect.width,
                             exp_res.rect.height, exp_res.x_off, exp_res.y_off);
                    $display("               actual:   left %0d top %0d w %0d h %0d x %0d y %0d",
                             got.rect.left, got.rect.top, got.rect.width, got.rect.height,
                             got.x_off, got.y_off);
                end
                crop_errs++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_alpha;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [11:0]        o_crop_left;
    logic [11:0]        o_crop_top;
    logic [12:0]        o_crop_width;
    logic [12:0]        o_crop_height;
    logic signed [15:0] o_new_x_offset;
    logic signed [15:0] o_new_y_offset;

    crop_box_ledger crops = new();
    bit             no_idle;
    bit             hold_req;
    int unsigned    sent_pixels;
    int unsigned    cycles;

    alpha_bounding_box_crop_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_alpha        (i_alpha),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_crop_left    (o_crop_left),
        .o_crop_top     (o_crop_top),
        .o_crop_width   (o_crop_width),
        .o_crop_height  (o_crop_height),
        .o_new_x_offset (o_new_x_offset),
        .o_new_y_offset (o_new_y_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            crops.check_crop({o_crop_left, o_crop_top, o_crop_width, o_crop_height,
                              o_new_x_offset, o_new_y_offset});
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        crops.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] a);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_alpha    <= a;
        do @(posedge i_clk); while (!o_in_ready);
        crops.note_pixel(a);
        sent_pixels++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (crops.crops_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_alpha(int unsigned vis_pct);
        logic [7:0] t;
        t = crops.tol;
        if ($urandom_range(0, 9) == 0) return t + 8'($urandom_range(0, 1));
        if (t != 8'hFF && $urandom_range(0, 99) < vis_pct)
            return 8'($urandom_range(int'(t) + 1, 255));
        return 8'($urandom_range(0, int'(t)));
    endfunction

    task automatic send_frame(input int unsigned vis_pct);
        int unsigned n0;
        n0 = crops.frames_seen;
        do send_pixel(pick_alpha(vis_pct)); while (crops.frames_seen == n0);
    endtask

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_prev();
        logic [11:0] p;
        case ($urandom_range(0, 3))
            0: p = 12'd0;
            1: p = 12'hFFF;
            default: p = 12'($urandom);
        endcase
        return {4'($urandom), p};
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 8;
            2: return 35;
            default: return 90;
        endcase
    endfunction

    task automatic random_setup();
        logic [12:0] w, h;
        logic [7:0]  t;
        w = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
        h = ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 5));
        case ($urandom_range(0, 3))
            0: t = 8'd0;
            1: t = 8'hFF;
            default: t = 8'($urandom);
        endcase
        write_cfg(CFG_IMAGE_WIDTH, {3'($urandom), w});
        write_cfg(CFG_IMAGE_HEIGHT, {3'($urandom), h});
        if ($urandom_range(0, 9) < 7) write_cfg(CFG_ALPHA_TOLERANCE, {8'($urandom), t});
        if ($urandom_range(0, 9) < 7) write_cfg(CFG_X_OFFSET, pick_offset());
        if ($urandom_range(0, 9) < 7) write_cfg(CFG_Y_OFFSET, pick_offset());
        if ($urandom_range(0, 9) < 7) write_cfg(CFG_PREV_CROP_LEFT, pick_prev());
        if ($urandom_range(0, 9) < 7) write_cfg(CFG_PREV_CROP_TOP, pick_prev());
        if ($urandom_range(0, 9) == 0) write_cfg(CFG_UNUSED_IDX, 16'($urandom));
    endtask

    initial begin
        int unsigned base;
        int unsigned phase;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IMAGE_WIDTH;
        i_cfg_data  = 16'd0;
        i_in_valid  = 1'b0;
        i_alpha     = 8'd0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        sent_pixels = 0;
        cycles      = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size 1x1: transparent, then visible
        send_pixel(8'h00);
        send_pixel(8'hFF);
        wait_idle();

        // zero width acts as 1; tolerance 255 hides everything
        write_cfg(CFG_IMAGE_WIDTH, 16'd0);
        write_cfg(CFG_IMAGE_HEIGHT, 16'd2);
        write_cfg(CFG_ALPHA_TOLERANCE, 16'd255);
        write_cfg(CFG_X_OFFSET, 16'h7FFF);
        write_cfg(CFG_Y_OFFSET, 16'h8000);
        write_cfg(CFG_PREV_CROP_LEFT, 16'd4095);
        write_cfg(CFG_PREV_CROP_TOP, 16'd0);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        wait_idle();

        // tolerance boundary and offset saturation both ways
        write_cfg(CFG_IMAGE_WIDTH, 16'd4);
        write_cfg(CFG_ALPHA_TOLERANCE, 16'h7F);
        write_cfg(CFG_X_OFFSET, 16'h8000);
        write_cfg(CFG_Y_OFFSET, 16'h7FFF);
        write_cfg(CFG_PREV_CROP_LEFT, 16'd0);
        write_cfg(CFG_PREV_CROP_TOP, 16'd4095);
        send_pixel(8'h00);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        wait_idle();

        // width shrinks below the column counter mid-frame
        write_cfg(CFG_IMAGE_WIDTH, 16'd6);
        write_cfg(CFG_IMAGE_HEIGHT, 16'd3);
        write_cfg(CFG_ALPHA_TOLERANCE, 16'd0);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h01);
        send_pixel(8'h00);
        wait_idle();
        write_cfg(CFG_IMAGE_WIDTH, 16'd2);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'h09);
        wait_idle();

        // oversized values clamp; a shrink mid-frame then ends the frame
        write_cfg(CFG_IMAGE_WIDTH, 16'h1FFF);
        write_cfg(CFG_IMAGE_HEIGHT, 16'd1);
        repeat (5) send_pixel(pick_alpha(35));
        wait_idle();
        write_cfg(CFG_IMAGE_WIDTH, 16'd3);
        send_pixel(pick_alpha(35));
        wait_idle();
        write_cfg(CFG_IMAGE_WIDTH, 16'd1);
        write_cfg(CFG_IMAGE_HEIGHT, 16'h1FFF);
        repeat (5) send_pixel(pick_alpha(35));
        wait_idle();
        write_cfg(CFG_IMAGE_HEIGHT, 16'd2);
        send_pixel(pick_alpha(35));
        wait_idle();

        base = sent_pixels;
        phase = 0;
        while (sent_pixels - base < RAND_PIXELS) begin
            no_idle = (sent_pixels - base >= 200) && (sent_pixels - base < 330);
            random_setup();
            if (phase == 5) begin
                // one-pixel frames against a stalled output
                write_cfg(CFG_IMAGE_WIDTH, 16'd1);
                write_cfg(CFG_IMAGE_HEIGHT, 16'd1);
                hold_req = 1'b1;
                repeat (30) send_pixel(pick_alpha(50));
            end else if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 8)) send_pixel(pick_alpha(35));
                wait_idle();
                write_cfg(CFG_IMAGE_WIDTH, {3'($urandom), 13'($urandom_range(1, 6))});
                write_cfg(CFG_IMAGE_HEIGHT, {3'($urandom), 13'($urandom_range(1, 5))});
                send_frame(pick_density());
            end else begin
                repeat ($urandom_range(1, 4)) send_frame(pick_density());
            end
            wait_idle();
            phase++;
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (crops.crops_due.size() != 0)
            $display("%0d crops never delivered", crops.crops_due.size());
        if (crops.crop_errs == 0 && crops.crops_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
